// ----- design/heightmap_store_sampler_assert.svh -----
// Assertion macros for the height grid sampler.
// Included by design files that carry concurrent checks; no other dependencies.
`ifndef HEIGHTMAP_STORE_SAMPLER_ASSERT_SVH
`define HEIGHTMAP_STORE_SAMPLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define HSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HSS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSS_ASSERT(lbl, prop, msg)
`define HSS_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ----- design/hss_pkg.sv -----
// Shared constants, codes and types of the height grid sampler.
// No dependencies.
package hss_pkg;
  localparam int GRID_SIZE_DEF = 64;
  localparam int FRAC_BITS_DEF = 8;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 24;
  localparam int H_W     = 32;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 32;
  localparam int ALIGN_W = 20;
  localparam int SPAN_W  = 31;

  localparam int NUM_W = 34;
  localparam int DEN_W = ALIGN_W + 1;
  localparam int QUO_W = NUM_W + 1;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BILIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TRI   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SPAN    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_MAX = 2'd3;

  localparam logic [ALIGN_W-1:0] ALIGN_RST = 20'd50;
  localparam logic [SPAN_W-1:0]  SPAN_RST  = 31'd10000000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

// ----- design/hss_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module hss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4225
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/hss_div.sv -----
// Iterative restoring unsigned divider, one quotient bit per cycle.
// Depends on hss_pkg.
module hss_div #(
  parameter int NW = hss_pkg::NUM_W,
  parameter int DW = hss_pkg::DEN_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NW-1:0]     num,
  input  logic [DW-1:0]     den,
  output hss_pkg::div_stat_t stat,
  output logic [NW-1:0]     quo,
  output logic [DW-1:0]     rem
);
  import hss_pkg::*;

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   quo_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic            busy_r;
  logic            done_r;
  logic [DW:0]     trial;
  logic            fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= fits ? DW'(trial - {1'b0, den_r}) : DW'(trial);
        quo_r <= {quo_r[NW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo = quo_r;
  assign rem = rem_r;
endmodule

// ----- design/heightmap_store_sampler.sv -----
// Height grid store with bilinear and split-triangle sampling.
// A stored write runs through the 34-step divider; a sample makes four grid reads
// through one RAM port and one shared multiplier. Ignored or rejected writes and the
// unused command end without a grid access. A new transaction is taken only once
// busy drops; busy drops in the result strobe cycle. The receiver cannot stall.
// After reset the grid is cleared one entry a cycle, all (GRID_SIZE+1)^2 entries.
module heightmap_store_sampler #(
  parameter int GRID_SIZE = hss_pkg::GRID_SIZE_DEF,
  parameter int FRAC_BITS = hss_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [hss_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [hss_pkg::POS_W-1:0]     in_x_pos,
  input  logic signed [hss_pkg::POS_W-1:0]     in_y_pos,
  input  logic signed [hss_pkg::H_W-1:0]       in_height_in,
  output logic                                 out_valid,
  output logic signed [hss_pkg::H_W-1:0]       out_height_out,
  output logic [hss_pkg::STAT_W-1:0]           out_status,
  input  logic                                 cfg_we,
  input  logic [hss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hss_pkg::CFG_W-1:0]            cfg_data
);
  import hss_pkg::*;
  `include "heightmap_store_sampler_assert.svh"

  localparam int SIDE  = GRID_SIZE + 1;
  localparam int CELLS = SIDE * SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(SIDE);
  localparam int FW    = FRAC_BITS + 1;
  localparam int WW    = 2 * FRAC_BITS + 1;
  localparam int MA    = QUO_W;
  localparam int MB    = (WW + 1 > DEN_W) ? WW + 1 : DEN_W;
  localparam int PRW   = MA + MB;
  localparam int ACW   = PRW + 2;
  localparam logic signed [31:0] TOP_POS = 32'(GRID_SIZE << FRAC_BITS);
  localparam logic [FW-1:0] S_ONE = FW'(1 << FRAC_BITS);
  localparam logic signed [PRW-1:0] I32_MAX = PRW'(64'sd2147483647);
  localparam logic signed [PRW-1:0] I32_MIN = PRW'(-64'sd2147483648);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WCHK, ST_WDIV, ST_WMUL, ST_WFIX,
    ST_SRD, ST_SMUL, ST_SACC, ST_SRND, ST_DONE
  } state_t;

  state_t state_r;
  logic [AW-1:0]            clr_r;
  logic                     tri_r;
  logic signed [POS_W-1:0]  xp_r, yp_r;
  logic signed [H_W-1:0]    h_r;
  logic [CW-1:0]            gx_r, gy_r;
  logic [FRAC_BITS-1:0]     fx_r, fy_r;
  logic [1:0]               k_r;
  logic [WW-1:0]            w_r;
  logic signed [ACW-1:0]    acc_r;
  logic signed [PRW-1:0]    prod_r;
  logic signed [MA-1:0]     q_r;
  logic                     neg_r;
  logic signed [H_W-1:0]    res_r;
  logic [STAT_W-1:0]        stat_r;
  logic                     out_valid_r;
  logic signed [H_W-1:0]    out_h_r;
  logic [STAT_W-1:0]        out_st_r;
  logic [ALIGN_W-1:0]       align_r;
  logic [SPAN_W-1:0]        span_r;
  logic signed [H_W-1:0]    low_r, high_r;

  // Sample position clamp
  logic signed [31:0] xs, ys, xc, yc;
  assign xs = 32'(in_x_pos);
  assign ys = 32'(in_y_pos);
  assign xc = (xs < 0) ? '0 : (xs > TOP_POS) ? TOP_POS : xs;
  assign yc = (ys < 0) ? '0 : (ys > TOP_POS) ? TOP_POS : ys;

  // Write checks
  logic [ALIGN_W-1:0]       a_eff;
  logic signed [POS_W-1:0]  gxw, gyw;
  logic                     pos_bad;
  logic signed [33:0]       hh, lo, hi, sp, diff, n;
  logic                     below, above, reject;
  logic [NUM_W-1:0]         nabs;

  assign a_eff   = (align_r == '0) ? ALIGN_W'(1) : align_r;
  assign gxw     = xp_r >>> FRAC_BITS;
  assign gyw     = yp_r >>> FRAC_BITS;
  assign pos_bad = (xp_r < 0) || (yp_r < 0) ||
                   (gxw > $signed(POS_W'(GRID_SIZE))) || (gyw > $signed(POS_W'(GRID_SIZE)));
  assign hh      = 34'(h_r);
  assign lo      = 34'(low_r);
  assign hi      = 34'(high_r);
  assign sp      = 34'(span_r);
  assign below   = hh < lo;
  assign above   = hh > hi;
  assign diff    = below ? (hi - hh) : (hh - lo);
  assign reject  = (below || above) && !(diff < sp);
  assign n       = (hh <<< 1) + 34'(a_eff);
  assign nabs    = n[33] ? NUM_W'(-n) : NUM_W'(n);

  div_stat_t          div_stat;
  logic               div_start;
  logic [NUM_W-1:0]   div_quo;
  logic [DEN_W-1:0]   div_rem;
  logic signed [MA-1:0] q_nxt;

  assign div_start = (state_r == ST_WCHK) && !pos_bad && !reject;
  assign q_nxt = neg_r ? (-MA'(div_quo) - MA'(div_rem != '0)) : MA'(div_quo);

  hss_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (nabs),
    .den   ({a_eff, 1'b0}),
    .stat  (div_stat),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Grid RAM
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [H_W-1:0]   ram_wdata, ram_rdata;
  logic signed [PRW-1:0] a_px, qa, qa_fix;
  logic [CW-1:0]    gx1, gy1, cx, cy;

  assign a_px   = PRW'(a_eff);
  assign qa     = prod_r;
  assign qa_fix = (qa > I32_MAX) ? (qa - a_px) : (qa < I32_MIN) ? (qa + a_px) : qa;
  assign gx1    = (gx_r == CW'(GRID_SIZE)) ? gx_r : gx_r + 1'b1;
  assign gy1    = (gy_r == CW'(GRID_SIZE)) ? gy_r : gy_r + 1'b1;
  assign cx     = k_r[0] ? gx1 : gx_r;
  assign cy     = k_r[1] ? gy1 : gy_r;

  assign ram_we    = (state_r == ST_CLEAR) || (state_r == ST_WFIX);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_r : AW'(gy_r) * AW'(SIDE) + AW'(gx_r);
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : H_W'(qa_fix);
  assign ram_raddr = AW'(cy) * AW'(SIDE) + AW'(cx);

  hss_ram #(.WIDTH(H_W), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Corner weights, scaled to 2^(2*FRAC_BITS)
  logic [FW-1:0]   fxw, fyw, wx, wy, tw;
  logic [FW:0]     fsum;
  logic            lower;
  logic [WW-1:0]   w_nxt;

  assign fxw   = FW'(fx_r);
  assign fyw   = FW'(fy_r);
  assign wx    = k_r[0] ? fxw : S_ONE - fxw;
  assign wy    = k_r[1] ? fyw : S_ONE - fyw;
  assign fsum  = (FW + 1)'(fxw) + (FW + 1)'(fyw);
  assign lower = fsum <= (FW + 1)'(S_ONE);
  always_comb begin
    unique case (k_r)
      2'd0:    tw = lower ? FW'((FW + 1)'(S_ONE) - fsum) : '0;
      2'd1:    tw = lower ? fxw : S_ONE - fyw;
      2'd2:    tw = lower ? fyw : S_ONE - fxw;
      default: tw = lower ? '0 : FW'(fsum - (FW + 1)'(S_ONE));
    endcase
  end
  assign w_nxt = tri_r ? (WW'(tw) << FRAC_BITS) : WW'(wx) * WW'(wy);

  // Shared multiplier
  logic signed [MA-1:0]  ma;
  logic signed [MB-1:0]  mb;
  logic signed [PRW-1:0] prod_nxt;
  logic signed [ACW-1:0] rnd;

  assign ma = (state_r == ST_WMUL) ? q_r : MA'($signed(ram_rdata));
  assign mb = (state_r == ST_WMUL) ? MB'(a_eff) : MB'(w_r);
  assign prod_nxt = ma * mb;
  assign rnd = acc_r + (ACW'(1) <<< (2 * FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      align_r     <= ALIGN_RST;
      span_r      <= SPAN_RST;
      low_r       <= '0;
      high_r      <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ALIGN:    align_r <= cfg_data[ALIGN_W-1:0];
          CFG_SPAN:     span_r  <= cfg_data[SPAN_W-1:0];
          CFG_INIT_MIN: low_r   <= $signed(cfg_data);
          default:      high_r  <= $signed(cfg_data);
        endcase
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(CELLS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            xp_r   <= in_x_pos;
            yp_r   <= in_y_pos;
            h_r    <= in_height_in;
            tri_r  <= (in_cmd == CMD_TRI);
            gx_r   <= CW'(xc >>> FRAC_BITS);
            gy_r   <= CW'(yc >>> FRAC_BITS);
            fx_r   <= xc[FRAC_BITS-1:0];
            fy_r   <= yc[FRAC_BITS-1:0];
            k_r    <= '0;
            acc_r  <= '0;
            res_r  <= '0;
            stat_r <= STAT_OK;
            if (in_cmd == CMD_WRITE) begin
              state_r <= ST_WCHK;
            end else if (in_cmd == CMD_BILIN || in_cmd == CMD_TRI) begin
              state_r <= ST_SRD;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_WCHK: begin
          gx_r  <= CW'(gxw);
          gy_r  <= CW'(gyw);
          neg_r <= n[33];
          if (pos_bad) begin
            stat_r  <= STAT_OUTSIDE;
            state_r <= ST_DONE;
          end else if (reject) begin
            stat_r  <= STAT_SPAN;
            state_r <= ST_DONE;
          end else begin
            if (below) begin
              low_r <= h_r;
            end else if (above) begin
              high_r <= h_r;
            end
            state_r <= ST_WDIV;
          end
        end
        ST_WDIV: begin
          if (div_stat.done) begin
            q_r     <= q_nxt;
            state_r <= ST_WMUL;
          end
        end
        ST_WMUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_WFIX;
        end
        ST_WFIX: begin
          state_r <= ST_DONE;
        end
        ST_SRD: begin
          w_r     <= w_nxt;
          state_r <= ST_SMUL;
        end
        ST_SMUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_SACC;
        end
        ST_SACC: begin
          acc_r <= acc_r + ACW'(prod_r);
          k_r   <= k_r + 1'b1;
          state_r <= (k_r == 2'd3) ? ST_SRND : ST_SRD;
        end
        ST_SRND: begin
          res_r   <= H_W'(rnd >>> (2 * FRAC_BITS));
          state_r <= ST_DONE;
        end
        default: begin
          out_valid_r <= 1'b1;
          out_h_r     <= res_r;
          out_st_r    <= stat_r;
          state_r     <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_height_out = out_h_r;
  assign out_status     = out_st_r;

  `HSS_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted transaction did not raise busy")
  `HSS_ASSERT(a_err_zero, out_valid && out_status != STAT_OK |-> out_height_out == 0, "error result carries nonzero height")
  `HSS_ASSERT(a_ram_we, ram_we |-> (state_r == ST_CLEAR || state_r == ST_WFIX), "grid write outside clear or store")
  `HSS_ASSERT_NR(a_reset_clear, !rst_n |=> busy, "block idle right after reset")
endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for heightmap_store_sampler: directed table, extreme-value writes, then random phases.
// Depends on hss_pkg and the block's RTL; grid model and interpolation predictor held locally.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hss_pkg::*;

  localparam int GRID = GRID_SIZE_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int SIDE = GRID + 1;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    int               x;
    int               y;
    int               h;
    bit               typed;
    int               exp_h;
    logic [STAT_W-1:0] exp_st;
  } stim_row_t;

  typedef struct {
    logic signed [H_W-1:0] h;
    logic [STAT_W-1:0]     st;
  } sample_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] in_cmd = '0;
  logic signed [POS_W-1:0] in_x_pos = '0;
  logic signed [POS_W-1:0] in_y_pos = '0;
  logic signed [H_W-1:0] in_height_in = '0;
  logic out_valid;
  logic signed [H_W-1:0] out_height_out;
  logic [STAT_W-1:0] out_status;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic typed_row = 1'b0;
  int typed_h = 0;
  logic [STAT_W-1:0] typed_st = STAT_OK;

  int grid_mem [SIDE*SIDE];
  longint low_mark, high_mark, align_step, max_span;
  sample_result_t pending_q[$];
  int errors = 0;
  int cycles = 0;

  wire accept = start && !busy;

  heightmap_store_sampler u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_x_pos(in_x_pos), .in_y_pos(in_y_pos),
    .in_height_in(in_height_in), .out_valid(out_valid),
    .out_height_out(out_height_out), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint grid_at(longint gx, longint gy);
    if (gx < 0) gx = 0;
    if (gy < 0) gy = 0;
    if (gx > GRID) gx = GRID;
    if (gy > GRID) gy = GRID;
    return longint'(grid_mem[gy*SIDE + gx]);
  endfunction

  function automatic sample_result_t grid_step(logic [CMD_W-1:0] c, longint xp, longint yp,
                                               longint h);
    sample_result_t r;
    longint s, gx, gy, fx, fy, v00, v01, v10, v11, num, den, a, q, top;
    r.h = '0;
    r.st = STAT_OK;
    s = longint'(1) << FRAC;
    top = longint'(GRID) << FRAC;
    if (c == CMD_WRITE) begin
      if (xp < 0 || yp < 0) begin
        r.st = STAT_OUTSIDE;
        return r;
      end
      gx = xp >> FRAC;
      gy = yp >> FRAC;
      if (gx > GRID || gy > GRID) begin
        r.st = STAT_OUTSIDE;
        return r;
      end
      if (h < low_mark) begin
        if (high_mark - h < max_span) low_mark = h;
        else begin
          r.st = STAT_SPAN;
          return r;
        end
      end else if (h > high_mark) begin
        if (h - low_mark < max_span) high_mark = h;
        else begin
          r.st = STAT_SPAN;
          return r;
        end
      end
      a = (align_step == 0) ? 1 : align_step;
      q = floor_div(2*h + a, 2*a) * a;
      if (q > 64'sd2147483647) q -= a;
      if (q < -64'sd2147483648) q += a;
      grid_mem[gy*SIDE + gx] = int'(q);
    end else if (c == CMD_BILIN || c == CMD_TRI) begin
      if (xp < 0) xp = 0;
      if (yp < 0) yp = 0;
      if (xp > top) xp = top;
      if (yp > top) yp = top;
      gx = xp >> FRAC;
      gy = yp >> FRAC;
      fx = xp & (s - 1);
      fy = yp & (s - 1);
      v00 = grid_at(gx, gy);
      v01 = grid_at(gx + 1, gy);
      v10 = grid_at(gx, gy + 1);
      v11 = grid_at(gx + 1, gy + 1);
      if (c == CMD_BILIN) begin
        num = (v00*(s - fy) + v10*fy)*(s - fx) + (v01*(s - fy) + v11*fy)*fx;
        den = s*s;
      end else if (fx + fy <= s) begin
        num = v00*(s - fx - fy) + v01*fx + v10*fy;
        den = s;
      end else begin
        num = v01*(s - fy) + v10*(s - fx) + v11*(fx + fy - s);
        den = s;
      end
      r.h = H_W'(floor_div(num + den/2, den));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    sample_result_t got, want;
    if (rst_n) begin
      if (out_valid) begin
        got.h = out_height_out;
        got.st = out_status;
        if (pending_q.size() == 0) begin
          $display("%0t unexpected result: actual h=%0d st=%0d", $time, got.h, got.st);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (got.h !== want.h) begin
            $display("%0t height_out mismatch: expected %0d actual %0d", $time, want.h, got.h);
            errors++;
          end
          if (got.st !== want.st) begin
            $display("%0t status mismatch: expected %0d actual %0d", $time, want.st, got.st);
            errors++;
          end
        end
      end
      if (accept) begin
        want = grid_step(in_cmd, longint'(in_x_pos), longint'(in_y_pos),
                         longint'(in_height_in));
        if (typed_row) begin
          want.h = typed_h;
          want.st = typed_st;
        end
        pending_q.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ALIGN:    align_step = longint'(val[ALIGN_W-1:0]);
      CFG_SPAN:     max_span = longint'(val[SPAN_W-1:0]);
      CFG_INIT_MIN: low_mark = longint'($signed(val));
      CFG_INIT_MAX: high_mark = longint'($signed(val));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(int a, int s, int lo, int hi);
    write_reg(CFG_ALIGN, a);
    write_reg(CFG_SPAN, s);
    write_reg(CFG_INIT_MIN, lo);
    write_reg(CFG_INIT_MAX, hi);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic send(stim_row_t r, bit may_idle);
    start <= 1'b1;
    in_cmd <= r.cmd;
    in_x_pos <= r.x[POS_W-1:0];
    in_y_pos <= r.y[POS_W-1:0];
    in_height_in <= r.h;
    typed_row <= r.typed;
    typed_h <= r.exp_h;
    typed_st <= r.exp_st;
    @(posedge clk iff accept);
    if (may_idle && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic stim_row_t rand_row();
    stim_row_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.typed = 1'b0;
    r.exp_h = 0;
    r.exp_st = STAT_OK;
    r.cmd = (pick < 40) ? CMD_WRITE : (pick < 68) ? CMD_BILIN : (pick < 96) ? CMD_TRI
                                                              : CMD_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      r.x = $urandom_range(0, 4 << FRAC);
      r.y = $urandom_range(0, 4 << FRAC);
    end else if (pick < 94) begin
      r.x = int'($urandom_range(0, (GRID + 2) << FRAC)) - 256;
      r.y = int'($urandom_range(0, (GRID + 2) << FRAC)) - 256;
    end else begin
      r.x = int'({$urandom()} << 8) >>> 8;
      r.y = int'({$urandom()} << 8) >>> 8;
    end
    r.h = ($urandom_range(0, 9) == 0) ? int'($urandom())
                                      : int'($urandom_range(0, 6000000)) - 3000000;
    return r;
  endfunction

  stim_row_t directed [] = '{
    '{CMD_BILIN, 0, 0, 0, 1'b1, 0, STAT_OK},
    '{CMD_TRI, 32'sh7FFFFF, 32'sh7FFFFF, 0, 1'b1, 0, STAT_OK},
    '{CMD_WRITE, -1, 0, 5, 1'b1, 0, STAT_OUTSIDE},
    '{CMD_WRITE, 0, -8388608, 5, 1'b1, 0, STAT_OUTSIDE},
    '{CMD_WRITE, (GRID + 1) << FRAC, 0, 5, 1'b1, 0, STAT_OUTSIDE},
    '{CMD_WRITE, 8388607, 8388607, 5, 1'b1, 0, STAT_OUTSIDE},
    '{CMD_WRITE, 0, 0, 20000000, 1'b1, 0, STAT_SPAN},
    '{CMD_WRITE, 0, 0, -20000000, 1'b1, 0, STAT_SPAN},
    '{CMD_UNUSED, 100, 100, -1, 1'b1, 0, STAT_OK},
    '{CMD_WRITE, 0, 0, 1024, 1'b1, 0, STAT_OK},
    '{CMD_WRITE, 256, 0, -2025, 1'b0, 0, STAT_OK},
    '{CMD_WRITE, 0, 511, 75, 1'b0, 0, STAT_OK},
    '{CMD_WRITE, 256, 256, 9999975, 1'b0, 0, STAT_OK},
    '{CMD_BILIN, 128, 128, 0, 1'b0, 0, STAT_OK},
    '{CMD_TRI, 100, 100, 0, 1'b0, 0, STAT_OK},
    '{CMD_TRI, 200, 200, 0, 1'b0, 0, STAT_OK},
    '{CMD_TRI, 0, 255, 0, 1'b0, 0, STAT_OK},
    '{CMD_TRI, 128, 128, 0, 1'b0, 0, STAT_OK},
    '{CMD_BILIN, -8388608, -8388608, 0, 1'b0, 0, STAT_OK},
    '{CMD_WRITE, GRID << FRAC, GRID << FRAC, -777, 1'b0, 0, STAT_OK},
    '{CMD_BILIN, 8388607, 8388607, 0, 1'b0, 0, STAT_OK},
    '{CMD_TRI, (GRID << FRAC) - 1, (GRID << FRAC) - 1, 0, 1'b0, 0, STAT_OK}
  };

  initial begin
    stim_row_t r;
    int n;
    for (int i = 0; i < SIDE*SIDE; i++) grid_mem[i] = 0;
    low_mark = 0;
    high_mark = 0;
    align_step = longint'(ALIGN_RST);
    max_span = longint'(SPAN_RST);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    foreach (directed[i]) send(directed[i], 1'b0);
    drain();
    typed_row <= 1'b0;

    // extremes of height and quantum
    set_regs(1, 32'h7FFFFFFF, 0, 0);
    r = '{CMD_WRITE, 0, 0, 32'sh7FFFFFFF, 1'b0, 0, STAT_OK};
    send(r, 1'b0);
    r.h = 32'sh80000000;
    send(r, 1'b0);
    drain();
    set_regs(1000000, 32'h7FFFFFFF, 32'sh80000000, 32'sh80000000);
    r = '{CMD_WRITE, 256, 0, 32'sh80000000, 1'b0, 0, STAT_OK};
    send(r, 1'b0);
    r.h = 2147483646;
    send(r, 1'b0);
    r.x = 0;
    r.h = 2147483647;
    send(r, 1'b0);
    r.cmd = CMD_BILIN;
    r.x = 128;
    send(r, 1'b0);
    drain();

    n = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_regs(50, 10000000, -4000000, 4000000);
        1: set_regs(1, 1, 0, 0);
        2: set_regs(1000000, 32'h7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        3: set_regs($urandom_range(1, 1000000), $urandom_range(1, 32'h7FFFFFFF),
                    $urandom(), $urandom());
        4: set_regs($urandom_range(1, 999), $urandom_range(1000000, 8000000),
                    3000000, -3000000);
        default: set_regs($urandom_range(1, 1000), 32'h7FFFFFFF, 0, 0);
      endcase
      for (int i = 0; i < 85; i++) begin
        send(rand_row(), !(n >= 150 && n < 300));
        n++;
        if (i == 40 && phase == 3) begin
          drain();
        end
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/hss_pkg.sv
design/hss_ram.sv
design/hss_div.sv
design/heightmap_store_sampler.sv
sim/testbench.sv
